// ===== rtl/core/fwsi_pkg.sv =====
// shared types and constants for the flow warp source index core
`default_nettype none

package fwsi_pkg;

  localparam int FlowDepth  = 4096;
  localparam int SlotW      = $clog2(FlowDepth);
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    CFG_GRID_COLS,
    CFG_GRID_ROWS,
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT,
    CFG_BLOCK_EDGE,
    CFG_BLOCKS_ACROSS,
    CFG_BLOCKS_DOWN
  } cfg_idx_t;

  typedef struct packed {
    logic               func;
    logic [11:0]        block_slot;
    logic signed [15:0] motion_dx;
    logic signed [15:0] motion_dy;
    logic [9:0]         cell_col;
    logic [9:0]         cell_row;
  } in_t;

  typedef struct packed {
    logic [9:0]  source_col;
    logic [9:0]  source_row;
    logic [19:0] source_index;
    logic [11:0] block_used;
  } out_t;

  // effective register values, already clamped to their legal ranges
  typedef struct packed {
    logic [10:0] cols;
    logic [10:0] rows;
    logic [12:0] fw;
    logic [12:0] fh;
    logic [8:0]  blk_edge;
    logic [8:0]  bx_cnt;
    logic [8:0]  by_cnt;
  } cfg_t;

  typedef struct packed {
    logic               func;
    logic [SlotW-1:0]   entry;
    logic signed [15:0] motion_dx;
    logic signed [15:0] motion_dy;
    logic [10:0]        col2p1;
    logic [10:0]        row2p1;
  } qitem_t;

endpackage

`default_nettype wire

// ===== rtl/core/fwsi_front.sv =====
// front part: accepts transactions and finds the motion block of each query
`default_nettype none

module fwsi_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire fwsi_pkg::cfg_t  cfg,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire fwsi_pkg::in_t   in_pl,
  output logic                 q_push,
  output fwsi_pkg::qitem_t     q_item,
  input  wire logic            q_full
);
  import fwsi_pkg::*;

  typedef struct packed {
    logic               func;
    logic [SlotW-1:0]   slot;
    logic signed [15:0] motion_dx;
    logic signed [15:0] motion_dy;
    logic [10:0]        c2;
    logic [10:0]        r2;
    logic [23:0]        remx;
    logic [23:0]        remy;
    logic [19:0]        denx;
    logic [19:0]        deny;
    logic               ovfx;
    logic               ovfy;
    logic [7:0]         qx;
    logic [7:0]         qy;
  } fdiv_t;

  typedef struct packed {
    logic               func;
    logic [SlotW-1:0]   slot;
    logic signed [15:0] motion_dx;
    logic signed [15:0] motion_dy;
    logic [10:0]        c2;
    logic [10:0]        r2;
    logic [7:0]         bx;
    logic [7:0]         by;
  } fclmp_t;

  function automatic fdiv_t ovf_chk(fdiv_t s);
    fdiv_t r;
    begin
      r = s;
      r.ovfx = {4'b0, s.remx} >= {s.denx, 8'b0};
      r.ovfy = {4'b0, s.remy} >= {s.deny, 8'b0};
      return r;
    end
  endfunction

  function automatic fdiv_t bit_step(fdiv_t s, int b);
    fdiv_t       r;
    logic [27:0] shx;
    logic [27:0] shy;
    begin
      r   = s;
      shx = {8'b0, s.denx} << b;
      shy = {8'b0, s.deny} << b;
      if (!s.ovfx && ({4'b0, s.remx} >= shx)) begin
        r.remx  = s.remx - shx[23:0];
        r.qx[b] = 1'b1;
      end
      if (!s.ovfy && ({4'b0, s.remy} >= shy)) begin
        r.remy  = s.remy - shy[23:0];
        r.qy[b] = 1'b1;
      end
      return r;
    end
  endfunction

  logic        f_adv;
  logic [9:0]  v_r;
  logic        c_vld_r;
  logic        e_vld_r;
  fdiv_t       d_r [0:9];
  fdiv_t       s0_nxt;
  fclmp_t      c_r;
  fclmp_t      c_nxt;
  qitem_t      e_r;
  qitem_t      e_nxt;
  logic [18:0] cbx;
  logic [18:0] cby;
  logic [7:0]  bxm1;
  logic [7:0]  bym1;
  logic [16:0] lin;

  assign f_adv    = !(e_vld_r && q_full);
  assign in_stall = !f_adv;
  assign q_push   = e_vld_r && !q_full;
  assign q_item   = e_r;

  assign cbx  = {8'b0, cfg.cols} * {10'b0, cfg.blk_edge};
  assign cby  = {8'b0, cfg.rows} * {10'b0, cfg.blk_edge};
  assign bxm1 = 8'(cfg.bx_cnt - 9'd1);
  assign bym1 = 8'(cfg.by_cnt - 9'd1);

  always_comb begin
    s0_nxt           = '0;
    s0_nxt.func      = in_pl.func;
    s0_nxt.slot      = in_pl.block_slot;
    s0_nxt.motion_dx = in_pl.motion_dx;
    s0_nxt.motion_dy = in_pl.motion_dy;
    s0_nxt.c2        = {in_pl.cell_col, 1'b1};
    s0_nxt.r2        = {in_pl.cell_row, 1'b1};
    s0_nxt.remx      = {13'b0, in_pl.cell_col, 1'b1} * {11'b0, cfg.fw};
    s0_nxt.remy      = {13'b0, in_pl.cell_row, 1'b1} * {11'b0, cfg.fh};
    s0_nxt.denx      = {cbx, 1'b0};
    s0_nxt.deny      = {cby, 1'b0};
  end

  always_comb begin
    c_nxt.func      = d_r[9].func;
    c_nxt.slot      = d_r[9].slot;
    c_nxt.motion_dx = d_r[9].motion_dx;
    c_nxt.motion_dy = d_r[9].motion_dy;
    c_nxt.c2        = d_r[9].c2;
    c_nxt.r2        = d_r[9].r2;
    c_nxt.bx        = (d_r[9].ovfx || d_r[9].qx > bxm1) ? bxm1 : d_r[9].qx;
    c_nxt.by        = (d_r[9].ovfy || d_r[9].qy > bym1) ? bym1 : d_r[9].qy;
  end

  assign lin = ({9'b0, c_r.by} * {8'b0, cfg.bx_cnt}) + {9'b0, c_r.bx};

  always_comb begin
    e_nxt.func      = c_r.func;
    e_nxt.entry     = (c_r.func == FUNC_QUERY) ? lin[SlotW-1:0] : c_r.slot;
    e_nxt.motion_dx = c_r.motion_dx;
    e_nxt.motion_dy = c_r.motion_dy;
    e_nxt.col2p1    = c_r.c2;
    e_nxt.row2p1    = c_r.r2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      c_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
    end else if (f_adv) begin
      v_r     <= {v_r[8:0], in_valid};
      c_vld_r <= v_r[9];
      e_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f_adv) begin
      d_r[0] <= s0_nxt;
      d_r[1] <= ovf_chk(d_r[0]);
      for (int k = 2; k <= 9; k++) begin
        d_r[k] <= bit_step(d_r[k-1], 9 - k);
      end
      c_r <= c_nxt;
      e_r <= e_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fwsi_fifo.sv =====
// short queue between the front and back parts
`default_nettype none

module fwsi_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire fwsi_pkg::qitem_t  push_item,
  output logic                   full,
  input  wire logic              pop,
  output fwsi_pkg::qitem_t       head_item,
  output logic                   empty
);
  import fwsi_pkg::*;

  qitem_t           mem_r [0:QueueDepth-1];
  logic [QPtrW-1:0] wr_ptr_r;
  logic [QPtrW-1:0] rd_ptr_r;
  logic [QPtrW:0]   cnt_r;

  assign head_item = mem_r[rd_ptr_r];
  assign empty     = (cnt_r == '0);
  assign full      = (cnt_r == (QPtrW+1)'(QueueDepth));

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPtrW+1)'(QueueDepth))
    else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/core/fwsi_back.sv =====
// back part: motion table, source cell division and result register
`default_nettype none

module fwsi_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fwsi_pkg::cfg_t    cfg,
  input  wire fwsi_pkg::qitem_t  q_item,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output fwsi_pkg::out_t         out_pl
);
  import fwsi_pkg::*;

  typedef struct packed {
    logic [SlotW-1:0] entry;
    logic [10:0]      c2;
    logic [10:0]      r2;
  } bmem_t;

  typedef struct packed {
    logic [SlotW-1:0]   entry;
    logic [25:0]        nx;
    logic [25:0]        ny;
    logic signed [27:0] px;
    logic signed [27:0] py;
  } bmul_t;

  typedef struct packed {
    logic [SlotW-1:0] entry;
    logic [26:0]      remx;
    logic [26:0]      remy;
    logic [16:0]      denx;
    logic [16:0]      deny;
    logic             negx;
    logic             negy;
    logic             ovfx;
    logic             ovfy;
    logic [9:0]       qx;
    logic [9:0]       qy;
  } bdiv_t;

  typedef struct packed {
    logic [SlotW-1:0] entry;
    logic [9:0]       sc;
    logic [9:0]       sr;
  } bclmp_t;

  function automatic bdiv_t bit_step(bdiv_t s, int b);
    bdiv_t       r;
    logic [26:0] shx;
    logic [26:0] shy;
    begin
      r   = s;
      shx = {10'b0, s.denx} << b;
      shy = {10'b0, s.deny} << b;
      if (!s.ovfx && (s.remx >= shx)) begin
        r.remx  = s.remx - shx;
        r.qx[b] = 1'b1;
      end
      if (!s.ovfy && (s.remy >= shy)) begin
        r.remy  = s.remy - shy;
        r.qy[b] = 1'b1;
      end
      return r;
    end
  endfunction

  logic               b_adv;
  logic [31:0]        vec_mem [0:FlowDepth-1];
  logic [31:0]        rd_r;
  logic               m_vld_r;
  bmem_t              m_r;
  bmem_t              m_nxt;
  logic               p_vld_r;
  bmul_t              p_r;
  bmul_t              p_nxt;
  logic [10:0]        bv_r;
  bdiv_t              bd_r [0:10];
  bdiv_t              bd0_nxt;
  logic               k_vld_r;
  bclmp_t             k_r;
  bclmp_t             k_nxt;
  logic               out_valid_r;
  out_t               out_r;
  out_t               out_nxt;
  logic signed [28:0] numx;
  logic signed [28:0] numy;
  logic [9:0]         cm1;
  logic [9:0]         rm1;

  assign b_adv     = !(out_valid_r && out_stall);
  assign q_pop     = b_adv && !q_empty;
  assign out_valid = out_valid_r;
  assign out_pl    = out_r;

  always_ff @(posedge clk) begin
    if (q_pop && q_item.func == FUNC_WRITE) begin
      vec_mem[q_item.entry] <= {q_item.motion_dy, q_item.motion_dx};
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      rd_r <= vec_mem[q_item.entry];
    end
  end

  assign m_nxt = '{entry: q_item.entry, c2: q_item.col2p1, r2: q_item.row2p1};

  always_comb begin
    p_nxt.entry = m_r.entry;
    p_nxt.nx    = {15'b0, m_r.c2} * {10'b0, cfg.fw, 3'b000};
    p_nxt.ny    = {15'b0, m_r.r2} * {10'b0, cfg.fh, 3'b000};
    p_nxt.px    = $signed(rd_r[15:0]) * $signed({1'b0, cfg.cols});
    p_nxt.py    = $signed(rd_r[31:16]) * $signed({1'b0, cfg.rows});
  end

  assign numx = $signed({3'b000, p_r.nx}) - p_r.px;
  assign numy = $signed({3'b000, p_r.ny}) - p_r.py;

  always_comb begin
    bd0_nxt       = '0;
    bd0_nxt.entry = p_r.entry;
    bd0_nxt.negx  = numx[28];
    bd0_nxt.negy  = numy[28];
    bd0_nxt.remx  = numx[28] ? '0 : numx[26:0];
    bd0_nxt.remy  = numy[28] ? '0 : numy[26:0];
    bd0_nxt.denx  = {cfg.fw, 4'b0000};
    bd0_nxt.deny  = {cfg.fh, 4'b0000};
    bd0_nxt.ovfx  = !numx[28] && (numx[26:0] >= {cfg.fw, 14'b0});
    bd0_nxt.ovfy  = !numy[28] && (numy[26:0] >= {cfg.fh, 14'b0});
  end

  assign cm1 = 10'(cfg.cols - 11'd1);
  assign rm1 = 10'(cfg.rows - 11'd1);

  always_comb begin
    k_nxt.entry = bd_r[10].entry;
    if (bd_r[10].negx) begin
      k_nxt.sc = '0;
    end else if (bd_r[10].ovfx || bd_r[10].qx > cm1) begin
      k_nxt.sc = cm1;
    end else begin
      k_nxt.sc = bd_r[10].qx;
    end
    if (bd_r[10].negy) begin
      k_nxt.sr = '0;
    end else if (bd_r[10].ovfy || bd_r[10].qy > rm1) begin
      k_nxt.sr = rm1;
    end else begin
      k_nxt.sr = bd_r[10].qy;
    end
  end

  always_comb begin
    out_nxt.source_col   = k_r.sc;
    out_nxt.source_row   = k_r.sr;
    out_nxt.source_index = ({10'b0, k_r.sr} * {9'b0, cfg.cols}) + {10'b0, k_r.sc};
    out_nxt.block_used   = k_r.entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r     <= 1'b0;
      p_vld_r     <= 1'b0;
      bv_r        <= '0;
      k_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (b_adv) begin
      m_vld_r     <= q_pop && q_item.func == FUNC_QUERY;
      p_vld_r     <= m_vld_r;
      bv_r        <= {bv_r[9:0], p_vld_r};
      k_vld_r     <= bv_r[10];
      out_valid_r <= k_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      m_r      <= m_nxt;
      p_r      <= p_nxt;
      bd_r[0]  <= bd0_nxt;
      for (int k = 1; k <= 10; k++) begin
        bd_r[k] <= bit_step(bd_r[k-1], 10 - k);
      end
      k_r      <= k_nxt;
      out_r    <= out_nxt;
    end
  end

  a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, out_r.source_col} < cfg.cols))
    else $error("source column outside grid");
  a_row_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, out_r.source_row} < cfg.rows))
    else $error("source row outside grid");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled transaction changed");

endmodule

`default_nettype wire

// ===== rtl/core/flow_warp_source_index_core.sv =====
// top level of the flow warp source index core
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | fwsi_pkg::in_t
//   out_    | output    | out_valid/out_stall | fwsi_pkg::out_t
//   cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// one transaction per cycle sustained while out_stall is low and in_stall is not raised; a query
// passes 12 front stages (block divide), the queue, then 15 back stages (cell divide)
// table writes produce no result and take effect in order at the table stage
// reset clears control only; table entries are undefined until written
// out_stall holds the back part, the queue absorbs the front until it fills
`default_nettype none

module flow_warp_source_index_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire fwsi_pkg::in_t   in_pl,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output fwsi_pkg::out_t       out_pl,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [12:0]     cfg_wdata
);
  import fwsi_pkg::*;

  function automatic logic [12:0] clamp_reg(logic [12:0] v, logic [12:0] hi);
    begin
      if (v == '0) begin
        return 13'd1;
      end else if (v > hi) begin
        return hi;
      end
      return v;
    end
  endfunction

  logic [10:0] cols_r;
  logic [10:0] rows_r;
  logic [12:0] fw_r;
  logic [12:0] fh_r;
  logic [8:0]  be_r;
  logic [8:0]  bxc_r;
  logic [8:0]  byc_r;
  cfg_t        cfg;
  logic        q_push;
  qitem_t      q_in;
  logic        q_full;
  logic        q_pop;
  qitem_t      q_head;
  logic        q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= 11'd80;
      rows_r <= 11'd24;
      fw_r   <= 13'd640;
      fh_r   <= 13'd480;
      be_r   <= 9'd16;
      bxc_r  <= 9'd40;
      byc_r  <= 9'd30;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GRID_COLS:     cols_r <= cfg_wdata[10:0];
        CFG_GRID_ROWS:     rows_r <= cfg_wdata[10:0];
        CFG_FRAME_WIDTH:   fw_r   <= cfg_wdata;
        CFG_FRAME_HEIGHT:  fh_r   <= cfg_wdata;
        CFG_BLOCK_EDGE:    be_r   <= cfg_wdata[8:0];
        CFG_BLOCKS_ACROSS: bxc_r  <= cfg_wdata[8:0];
        CFG_BLOCKS_DOWN:   byc_r  <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.cols     = 11'(clamp_reg({2'b0, cols_r}, 13'd1024));
    cfg.rows     = 11'(clamp_reg({2'b0, rows_r}, 13'd1024));
    cfg.fw       = clamp_reg(fw_r, 13'd4096);
    cfg.fh       = clamp_reg(fh_r, 13'd4096);
    cfg.blk_edge = 9'(clamp_reg({4'b0, be_r}, 13'd256));
    cfg.bx_cnt   = 9'(clamp_reg({4'b0, bxc_r}, 13'd256));
    cfg.by_cnt   = 9'(clamp_reg({4'b0, byc_r}, 13'd256));
  end

  fwsi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_pl    (in_pl),
    .q_push   (q_push),
    .q_item   (q_in),
    .q_full   (q_full)
  );

  fwsi_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head_item (q_head),
    .empty     (q_empty)
  );

  fwsi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_item    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pl    (out_pl)
  );

endmodule

`default_nettype wire
